// ===== src/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants for the line sensor steering controller
// Action and maneuver codes, register indexes, reset values and the rule table.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int unsigned SampleBitsDef = 10;
  localparam int unsigned NumChannels   = 4;

  // filter weights, in hundredths
  localparam int unsigned WeightPrev = 15;
  localparam int unsigned WeightNew  = 85;
  localparam int unsigned WeightSum  = 100;

  localparam int unsigned DutyBits  = 8;
  localparam int unsigned CfgIdxBits = 2;

  localparam logic [DutyBits-1:0] CruiseRst = 8'd160;
  localparam logic [DutyBits-1:0] PivotRst  = 8'd110;
  localparam logic [DutyBits-1:0] NudgeRst  = 8'd60;

  localparam logic [7:0] HoldNone  = 8'd0;
  localparam logic [7:0] HoldNudge = 8'd20;
  localparam logic [7:0] HoldPivot = 8'd100;
  localparam logic [7:0] HoldTurn  = 8'd200;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] CfgCruise = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgPivot  = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgNudge  = 2'd2;
  localparam logic [CfgIdxBits-1:0] CfgDark   = 2'd3;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_CAL   = 2'd1,
    ACT_RUN   = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    MV_STRAIGHT = 3'd0,
    MV_LEFT     = 3'd1,
    MV_RIGHT    = 3'd2,
    MV_SOFTL    = 3'd3,
    MV_SOFTR    = 3'd4,
    MV_TURN     = 3'd5
  } maneuver_e;

  // per-channel control, common to all four lanes
  typedef struct packed {
    logic    fire;    // item leaves the input register this cycle
    action_e action;
    logic    seeded;  // filter already running
    logic    dark;    // black line on white
  } chan_ctl_t;

  // pattern: front bit 3, left bit 2, center bit 1, right bit 0
  function automatic maneuver_e rule_lookup(input logic [3:0] pattern);
    maneuver_e mv;
    unique case (pattern)
      4'b0000, 4'b0001,
      4'b1000, 4'b1001: mv = MV_LEFT;
      4'b1100:          mv = MV_RIGHT;
      4'b1011, 4'b1101: mv = MV_SOFTL;
      4'b1110:          mv = MV_SOFTR;
      4'b1111:          mv = MV_TURN;
      default:          mv = MV_STRAIGHT;
    endcase
    return mv;
  endfunction

endpackage

// ===== src/line_sensor_steering_controller.sv =====
// ----------------------------------------------------------------------------
// line_sensor_steering_controller: line follower steering from four sensors
// Calibrates per-sensor bounds, smooths run samples, thresholds them and maps
// the 4-bit pattern to a maneuver with motor duties and a hold time.
// ----------------------------------------------------------------------------
// Path: an accepted run transaction goes to the input register, then to the
//   result register, where its result is offered until it is taken.
// Throughput: one transaction per cycle; each item's filter, threshold and
//   rule lookup are done in the single stage between the two registers.
//   A run waits in the input register only while an untaken result is held.
// Reset (rst_ni low, async): bounds to all ones / zero, filter unseeded,
//   duty registers to 160 / 110 / 60, white-line mode, both stages empty.
// ----------------------------------------------------------------------------
module line_sensor_steering_controller #(
  parameter int unsigned SampleBits = lss_pkg::SampleBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [lss_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [lss_pkg::DutyBits-1:0]        cfg_wdata_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          action_i,
  input  logic [SampleBits-1:0]               front_sample_i,
  input  logic [SampleBits-1:0]               left_sample_i,
  input  logic [SampleBits-1:0]               center_sample_i,
  input  logic [SampleBits-1:0]               right_sample_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lss_pkg::DutyBits-1:0]        left_forward_duty_o,
  output logic [lss_pkg::DutyBits-1:0]        left_reverse_duty_o,
  output logic [lss_pkg::DutyBits-1:0]        right_forward_duty_o,
  output logic [lss_pkg::DutyBits-1:0]        right_reverse_duty_o,
  output logic [7:0]                          hold_ms_o,
  output logic [2:0]                          maneuver_o,
  output logic [3:0]                          pattern_o
);
  import lss_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers. Write only while the block is idle; not enforced.
  // --------------------------------------------------------------------------
  logic [DutyBits-1:0] cruise_q, pivot_q, nudge_q;
  logic                dark_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cruise_q <= CruiseRst;
      pivot_q  <= PivotRst;
      nudge_q  <= NudgeRst;
      dark_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgCruise: cruise_q <= cfg_wdata_i;
        CfgPivot:  pivot_q  <= cfg_wdata_i;
        CfgNudge:  nudge_q  <= cfg_wdata_i;
        CfgDark:   dark_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register. A transaction leaves it ("fire") when it needs no result
  // slot (clear, calibrate, unused code) or when the result register is free
  // or being drained in the same cycle. Lane state updates on fire, so the
  // next transaction sees it in the following cycle with no bubble.
  // --------------------------------------------------------------------------
  logic                  in_valid_q;
  action_e               action_q;
  logic [SampleBits-1:0] samp_q [NumChannels];
  logic                  out_valid_q;
  logic                  out_free;
  logic                  is_run;
  logic                  fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign is_run     = (action_q == ACT_RUN);
  assign fire       = in_valid_q && (!is_run || out_free);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      action_q  <= action_e'(action_i);
      samp_q[0] <= front_sample_i;
      samp_q[1] <= left_sample_i;
      samp_q[2] <= center_sample_i;
      samp_q[3] <= right_sample_i;
    end
  end

  // Seed flag: cleared by clear and calibrate, set by the first run after.
  logic seeded_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q <= 1'b0;
    end else if (fire) begin
      unique case (action_q)
        ACT_CLEAR, ACT_CAL: seeded_q <= 1'b0;
        ACT_RUN:            seeded_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sensor lanes: 0 front, 1 left, 2 center, 3 right.
  // --------------------------------------------------------------------------
  chan_ctl_t              ctl;
  logic [NumChannels-1:0] lane_bit;
  logic [3:0]             pattern;

  assign ctl.fire   = fire;
  assign ctl.action = action_q;
  assign ctl.seeded = seeded_q;
  assign ctl.dark   = dark_q;

  for (genvar c = 0; c < NumChannels; c++) begin : g_lane
    lss_channel #(
      .SampleBits(SampleBits)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .sample_i(samp_q[c]),
      .bit_o   (lane_bit[c])
    );
  end

  // front lands in bit 3
  assign pattern = {lane_bit[0], lane_bit[1], lane_bit[2], lane_bit[3]};

  // --------------------------------------------------------------------------
  // Rule table and motor command decode.
  // --------------------------------------------------------------------------
  maneuver_e           mv;
  logic [DutyBits-1:0] lf_d, lr_d, rf_d, rr_d;
  logic [7:0]          hold_d;

  assign mv = rule_lookup(pattern);

  always_comb begin
    lf_d   = '0;
    lr_d   = '0;
    rf_d   = '0;
    rr_d   = '0;
    hold_d = HoldNone;
    unique case (mv)
      MV_LEFT: begin
        lr_d = pivot_q; rf_d = pivot_q; hold_d = HoldPivot;
      end
      MV_RIGHT: begin
        lf_d = pivot_q; rr_d = pivot_q; hold_d = HoldPivot;
      end
      MV_TURN: begin
        lr_d = pivot_q; rf_d = pivot_q; hold_d = HoldTurn;
      end
      MV_SOFTL: begin
        lr_d = nudge_q; rf_d = nudge_q; hold_d = HoldNudge;
      end
      MV_SOFTR: begin
        lf_d = nudge_q; rr_d = nudge_q; hold_d = HoldNudge;
      end
      default: begin
        lf_d = cruise_q; rf_d = cruise_q; hold_d = HoldNone;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Result register. Loaded only by run transactions; holds until taken.
  // --------------------------------------------------------------------------
  logic                load_out;
  logic [DutyBits-1:0] lf_q, lr_q, rf_q, rr_q;
  logic [7:0]          hold_q;
  maneuver_e           mv_q;
  logic [3:0]          pattern_q;

  assign load_out = fire && is_run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      lf_q      <= lf_d;
      lr_q      <= lr_d;
      rf_q      <= rf_d;
      rr_q      <= rr_d;
      hold_q    <= hold_d;
      mv_q      <= mv;
      pattern_q <= pattern;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign left_forward_duty_o  = lf_q;
  assign left_reverse_duty_o  = lr_q;
  assign right_forward_duty_o = rf_q;
  assign right_reverse_duty_o = rr_q;
  assign hold_ms_o            = hold_q;
  assign maneuver_o           = mv_q;
  assign pattern_o            = pattern_q;

endmodule

// ===== src/lss_channel.sv =====
// ----------------------------------------------------------------------------
// lss_channel: one sensor lane
// Holds the lane's bounds and smoothed level, filters a run sample and
// thresholds it against the lane midpoint.
// ----------------------------------------------------------------------------
module lss_channel #(
  parameter int unsigned SampleBits = lss_pkg::SampleBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lss_pkg::chan_ctl_t    ctl_i,
  input  logic [SampleBits-1:0] sample_i,
  output logic                  bit_o
);
  import lss_pkg::*;

  // weighted sum fits below 100 * 2^SampleBits
  localparam int unsigned NumBits   = SampleBits + 7;
  localparam int unsigned DivRecip  = (1 << NumBits) / WeightSum;
  localparam int unsigned RecipBits = $clog2(DivRecip + 1);
  localparam int unsigned ProdBits  = NumBits + RecipBits;

  logic [SampleBits-1:0] min_q, max_q, level_q;
  logic [SampleBits:0]   mid_sum;
  logic [SampleBits-1:0] mid;
  logic [SampleBits-1:0] prev;
  logic [NumBits-1:0]    num;
  logic [ProdBits-1:0]   prod;
  logic [SampleBits-1:0] quot0;
  logic [NumBits-1:0]    rem;
  logic [SampleBits-1:0] lvl;

  assign mid_sum = {1'b0, max_q} + {1'b0, min_q};
  assign mid     = mid_sum[SampleBits:1];
  assign prev    = ctl_i.seeded ? level_q : mid;

  assign num = NumBits'(prev) * NumBits'(WeightPrev)
             + NumBits'(sample_i) * NumBits'(WeightNew);

  // divide by 100: reciprocal estimate is low by at most one
  assign prod  = ProdBits'(num) * ProdBits'(DivRecip);
  assign quot0 = prod[NumBits +: SampleBits];
  assign rem   = num - NumBits'(quot0) * NumBits'(WeightSum);
  assign lvl   = (rem >= NumBits'(WeightSum)) ? quot0 + 1'b1 : quot0;

  assign bit_o = ctl_i.dark ? !(lvl > mid) : !(lvl < mid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= '1;
      max_q   <= '0;
      level_q <= '0;
    end else if (ctl_i.fire) begin
      unique case (ctl_i.action)
        ACT_CLEAR: begin
          min_q <= '1;
          max_q <= '0;
        end
        ACT_CAL: begin
          if (sample_i > max_q) max_q <= sample_i;
          if (sample_i < min_q) min_q <= sample_i;
        end
        ACT_RUN: begin
          level_q <= lvl;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== tb/steering_checker.sv =====
// ----------------------------------------------------------------------------
// steering_checker: scoreboard for the line sensor steering controller
// Watches the register port and both channels, keeps its own copy of the
// calibration bounds, filter levels and duty settings, predicts each drive
// command and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module steering_checker #(
  parameter int unsigned SampleBits = lss_pkg::SampleBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lss_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [lss_pkg::DutyBits-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [1:0]                     action_i,
  input  logic [SampleBits-1:0]          front_sample_i,
  input  logic [SampleBits-1:0]          left_sample_i,
  input  logic [SampleBits-1:0]          center_sample_i,
  input  logic [SampleBits-1:0]          right_sample_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [lss_pkg::DutyBits-1:0]   lf_duty_i,
  input  logic [lss_pkg::DutyBits-1:0]   lr_duty_i,
  input  logic [lss_pkg::DutyBits-1:0]   rf_duty_i,
  input  logic [lss_pkg::DutyBits-1:0]   rr_duty_i,
  input  logic [7:0]                     hold_ms_i,
  input  logic [2:0]                     maneuver_i,
  input  logic [3:0]                     pattern_i,
  output int unsigned                    err_count_o,
  output int unsigned                    pending_o
);
  import lss_pkg::*;

  typedef logic [NumChannels-1:0][SampleBits-1:0] sample_set_t;

  typedef struct packed {
    logic [DutyBits-1:0] lf;
    logic [DutyBits-1:0] lr;
    logic [DutyBits-1:0] rf;
    logic [DutyBits-1:0] rr;
    logic [7:0]          hold;
    maneuver_e           mv;
    logic [3:0]          pattern;
  } drive_cmd_t;

  // channel 3 is front, 0 is right: index matches the pattern bit
  sample_set_t         lo_bound;
  sample_set_t         hi_bound;
  sample_set_t         level;
  logic                primed;
  logic [DutyBits-1:0] cruise;
  logic [DutyBits-1:0] pivot;
  logic [DutyBits-1:0] nudge;
  logic                dark;

  drive_cmd_t  drive_cmd_q[$];
  int unsigned errs = 0;

  // first few dozen lines are enough to debug; the count keeps going
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (errs < 40) begin
      $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    end
    errs++;
  endtask

  task automatic predict_drive(input logic [1:0] act, input sample_set_t smp);
    int unsigned mid;
    int unsigned lvl;
    logic        hit;
    drive_cmd_t  cmd;
    cmd = '0;
    case (act)
      ACT_CLEAR: begin
        lo_bound = '1;
        hi_bound = '0;
        primed   = 1'b0;
      end
      ACT_CAL: begin
        for (int c = 0; c < NumChannels; c++) begin
          if (smp[c] > hi_bound[c]) hi_bound[c] = smp[c];
          if (smp[c] < lo_bound[c]) lo_bound[c] = smp[c];
        end
        primed = 1'b0;
      end
      ACT_RUN: begin
        for (int c = 0; c < NumChannels; c++) begin
          mid = 32'(hi_bound[c]);
          mid = (mid + lo_bound[c]) >> 1;
          if (!primed) level[c] = mid[SampleBits-1:0];
          lvl = (WeightPrev * level[c] + WeightNew * smp[c]) / WeightSum;
          level[c] = lvl[SampleBits-1:0];
          hit = dark ? (lvl <= mid) : (lvl >= mid);
          cmd.pattern[c] = hit;
        end
        primed = 1'b1;
        case (cmd.pattern)
          4'b0000, 4'b0001, 4'b1000, 4'b1001: cmd.mv = MV_LEFT;
          4'b1100:                            cmd.mv = MV_RIGHT;
          4'b1011, 4'b1101:                   cmd.mv = MV_SOFTL;
          4'b1110:                            cmd.mv = MV_SOFTR;
          4'b1111:                            cmd.mv = MV_TURN;
          default:                            cmd.mv = MV_STRAIGHT;
        endcase
        case (cmd.mv)
          MV_LEFT: begin
            cmd.lr = pivot; cmd.rf = pivot; cmd.hold = HoldPivot;
          end
          MV_RIGHT: begin
            cmd.lf = pivot; cmd.rr = pivot; cmd.hold = HoldPivot;
          end
          MV_TURN: begin
            cmd.lr = pivot; cmd.rf = pivot; cmd.hold = HoldTurn;
          end
          MV_SOFTL: begin
            cmd.lr = nudge; cmd.rf = nudge; cmd.hold = HoldNudge;
          end
          MV_SOFTR: begin
            cmd.lf = nudge; cmd.rr = nudge; cmd.hold = HoldNudge;
          end
          default: begin
            cmd.lf = cruise; cmd.rf = cruise; cmd.hold = HoldNone;
          end
        endcase
        drive_cmd_q.push_back(cmd);
      end
      default: ;  // unused action code: no state change
    endcase
  endtask

  task automatic check_drive();
    drive_cmd_t want;
    if (drive_cmd_q.size() == 0) begin
      report_mismatch("unexpected result, pattern", 32'(pattern_i), 0);
    end else begin
      want = drive_cmd_q.pop_front();
      if (pattern_i !== want.pattern)
        report_mismatch("pattern", 32'(pattern_i), 32'(want.pattern));
      if (maneuver_i !== want.mv)
        report_mismatch("maneuver", 32'(maneuver_i), 32'(want.mv));
      if (lf_duty_i !== want.lf)
        report_mismatch("left_forward_duty", 32'(lf_duty_i), 32'(want.lf));
      if (lr_duty_i !== want.lr)
        report_mismatch("left_reverse_duty", 32'(lr_duty_i), 32'(want.lr));
      if (rf_duty_i !== want.rf)
        report_mismatch("right_forward_duty", 32'(rf_duty_i), 32'(want.rf));
      if (rr_duty_i !== want.rr)
        report_mismatch("right_reverse_duty", 32'(rr_duty_i), 32'(want.rr));
      if (hold_ms_i !== want.hold)
        report_mismatch("hold_ms", 32'(hold_ms_i), 32'(want.hold));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_bound = '1;
      hi_bound = '0;
      level    = '0;
      primed   = 1'b0;
      cruise   = CruiseRst;
      pivot    = PivotRst;
      nudge    = NudgeRst;
      dark     = 1'b0;
      drive_cmd_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgCruise: cruise = cfg_wdata_i;
          CfgPivot:  pivot  = cfg_wdata_i;
          CfgNudge:  nudge  = cfg_wdata_i;
          CfgDark:   dark   = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predict_drive(action_i, {front_sample_i, left_sample_i, center_sample_i,
                                 right_sample_i});
      end
      if (out_valid_i && out_ready_i) check_drive();
      pending_o <= drive_cmd_q.size();
    end
    err_count_o <= errs;
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the line sensor steering controller
// Drives calibrate / clear / run transactions in random bursts against a
// randomly stalling result sink, across several duty and polarity settings;
// the steering checker predicts every drive command and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
  import lss_pkg::*;

  localparam int unsigned SampleBits = SampleBitsDef;
  // a result passes the input and result registers; margin before registers
  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned PhaseItems    = 345;
  // the one action code that the block ignores
  localparam logic [1:0]  ActIgnored    = 2'd3;

  typedef logic [NumChannels-1:0][SampleBits-1:0] sample_set_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index_i    = '0;
  logic [DutyBits-1:0]   cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            action_i       = '0;
  logic [SampleBits-1:0] front_sample_i  = '0;
  logic [SampleBits-1:0] left_sample_i   = '0;
  logic [SampleBits-1:0] center_sample_i = '0;
  logic [SampleBits-1:0] right_sample_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [DutyBits-1:0]   left_forward_duty_o;
  logic [DutyBits-1:0]   left_reverse_duty_o;
  logic [DutyBits-1:0]   right_forward_duty_o;
  logic [DutyBits-1:0]   right_reverse_duty_o;
  logic [7:0]            hold_ms_o;
  logic [2:0]            maneuver_o;
  logic [3:0]            pattern_o;

  int unsigned err_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  bit          hold_off_req  = 1'b0;
  bit          hold_off_done = 1'b0;

  always #1 clk_i = ~clk_i;

  line_sensor_steering_controller #(
    .SampleBits(SampleBits)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .action_i            (action_i),
    .front_sample_i      (front_sample_i),
    .left_sample_i       (left_sample_i),
    .center_sample_i     (center_sample_i),
    .right_sample_i      (right_sample_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .left_forward_duty_o (left_forward_duty_o),
    .left_reverse_duty_o (left_reverse_duty_o),
    .right_forward_duty_o(right_forward_duty_o),
    .right_reverse_duty_o(right_reverse_duty_o),
    .hold_ms_o           (hold_ms_o),
    .maneuver_o          (maneuver_o),
    .pattern_o           (pattern_o)
  );

  steering_checker #(
    .SampleBits(SampleBits)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .action_i       (action_i),
    .front_sample_i (front_sample_i),
    .left_sample_i  (left_sample_i),
    .center_sample_i(center_sample_i),
    .right_sample_i (right_sample_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .lf_duty_i      (left_forward_duty_o),
    .lr_duty_i      (left_reverse_duty_o),
    .rf_duty_i      (right_forward_duty_o),
    .rr_duty_i      (right_reverse_duty_o),
    .hold_ms_i      (hold_ms_o),
    .maneuver_i     (maneuver_o),
    .pattern_i      (pattern_o),
    .err_count_o    (err_count),
    .pending_o      (pending)
  );

  // Watchdog: covers a hung handshake and any command that never shows up.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result sink. Ready follows a mode that changes after each random stretch:
  // always ready, coin flip, mostly ready, mostly stalled. Once the stimulus
  // asks for it, ready is held low for a long stretch so the two pipeline
  // registers fill and in_ready_o drops while the sender keeps offering.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stretch;
    int unsigned mode;
    stretch = 0;
    mode    = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_done = 1'b1;
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(0, 3);
          stretch = $urandom_range(16, 64);
        end
        stretch--;
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Mostly full-scale random, with the rails showing up often.
  function automatic logic [SampleBits-1:0] draw_level();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return SampleBits'($urandom_range(0, (1 << SampleBits) - 1));
  endfunction

  function automatic sample_set_t draw_set();
    sample_set_t smp;
    for (int c = 0; c < NumChannels; c++) smp[c] = draw_level();
    return smp;
  endfunction

  // One transaction. Called right after a rising edge. Between bursts valid
  // drops for a random gap; inside a burst it stays high back to back.
  task automatic send_item(input logic [1:0] act, input sample_set_t smp);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    front_sample_i  <= smp[3];
    left_sample_i   <= smp[2];
    center_sample_i <= smp[1];
    right_sample_i  <= smp[0];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
  endtask

  // Stop offering and wait until every predicted command has come back, then
  // let the pipeline settle (clear / calibrate transactions leave no trace).
  // pending is updated at the edge, so wait for an edge before looking.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Leaves the write enable high; load_settings lowers it after the last one.
  task automatic reg_write(input logic [CfgIdxBits-1:0] idx,
                           input logic [DutyBits-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // dark_word: only bit 0 counts, the upper bits check that they are ignored
  task automatic load_settings(input logic [DutyBits-1:0] cruise,
                               input logic [DutyBits-1:0] pivot,
                               input logic [DutyBits-1:0] nudge,
                               input logic [DutyBits-1:0] dark_word);
    reg_write(CfgCruise, cruise);
    reg_write(CfgPivot, pivot);
    reg_write(CfgNudge, nudge);
    reg_write(CfgDark, dark_word);
    cfg_we_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Random traffic. Most of it is well-formed: clear, a few calibration
  // samples, then a run of run samples. A third of those runs open with
  // samples exactly at the channel midpoints, so the freshly seeded filter
  // lands on the threshold. The rest is noise: random action codes
  // (including the ignored one) in random order.
  // --------------------------------------------------------------------------
  task automatic run_sequences(input int unsigned quota);
    int unsigned  sent;
    int unsigned  n_cal;
    int unsigned  n_run;
    int unsigned  n_noise;
    bit           on_mid;
    logic [1:0]   act;
    logic [SampleBits:0] span_sum;
    sample_set_t  lo;
    sample_set_t  hi;
    sample_set_t  smp;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 9) < 8) begin
        send_item(ACT_CLEAR, draw_set());
        lo    = '1;
        hi    = '0;
        n_cal = $urandom_range(1, 4);
        for (int k = 0; k < n_cal; k++) begin
          smp = draw_set();
          for (int c = 0; c < NumChannels; c++) begin
            if (smp[c] < lo[c]) lo[c] = smp[c];
            if (smp[c] > hi[c]) hi[c] = smp[c];
          end
          send_item(ACT_CAL, smp);
        end
        on_mid = ($urandom_range(0, 2) == 0);
        n_run  = $urandom_range(2, 14);
        for (int k = 0; k < n_run; k++) begin
          smp = draw_set();
          if (k == 0 && on_mid) begin
            for (int c = 0; c < NumChannels; c++) begin
              span_sum = {1'b0, lo[c]} + {1'b0, hi[c]};
              smp[c]   = span_sum[SampleBits:1];
            end
          end
          send_item(ACT_RUN, smp);
        end
        sent += 1 + n_cal + n_run;
      end else begin
        n_noise = $urandom_range(1, 6);
        for (int k = 0; k < n_noise; k++) begin
          act = 2'($urandom_range(0, 3));
          send_item(act, draw_set());
          if (act != ActIgnored) sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    sample_set_t smp;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed, reset settings (white line, 160/110/60) ----
    // No calibration yet: every midpoint is 511. Rail samples push the
    // filtered level across it either way, so each run hits its pattern
    // directly: sweep all 16, which covers every maneuver.
    for (int p = 0; p < 16; p++) begin
      for (int c = 0; c < NumChannels; c++) smp[c] = p[c] ? '1 : '0;
      send_item(ACT_RUN, smp);
    end
    send_item(ActIgnored, draw_set());
    // after clear, two calibration samples give midpoints 200/511/511/200;
    // the first run reseeds there and a sample at the midpoint keeps the
    // level exactly on the threshold
    send_item(ACT_CLEAR, draw_set());
    send_item(ACT_CAL, {10'd100, 10'd0, 10'd1023, 10'd300});
    send_item(ACT_CAL, {10'd300, 10'd1023, 10'd0, 10'd100});
    send_item(ACT_RUN, {10'd200, 10'd511, 10'd511, 10'd200});
    // calibration at both rails, then a run that has to reseed
    send_item(ACT_CAL, '0);
    send_item(ACT_CAL, '1);
    send_item(ACT_RUN, {10'd1023, 10'd0, 10'd1023, 10'd0});
    drain();

    // ---- random phases, each with its own register settings ----
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: load_settings(8'd255, 8'd0, 8'd255, 8'h01);
        1: load_settings(8'd0, 8'd255, 8'd0, {7'($urandom), 1'b0});
        2: load_settings(DutyBits'($urandom), DutyBits'($urandom), DutyBits'($urandom),
                         {7'($urandom), 1'b1});
        default: load_settings(DutyBits'($urandom), DutyBits'($urandom),
                               DutyBits'($urandom), DutyBits'($urandom));
      endcase
      // the long receiver hold-off lands early in the first random phase
      if (ph == 0) hold_off_req = 1'b1;
      run_sequences(PhaseItems);
      drain();
    end

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== line_sensor_steering_controller.f =====
src/lss_pkg.sv
src/lss_channel.sv
src/line_sensor_steering_controller.sv
tb/steering_checker.sv
tb/tb_top.sv
